// File: rtl/core/spit_pkg.sv
// Package for the speed profile interpolation table.
// Holds op codes, status codes, field widths and the queue word type.
// No dependencies.
`timescale 1ns / 1ps
package spit_pkg;
	localparam int STEP_W = 10;
	localparam int SPEED_W = 24;
	localparam int DEF_ENTRIES = 32;
	localparam int DEF_FULL_SCALE = 1000;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_DELETE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_DATA = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// one command word between the front and the back
	typedef struct packed {
		op_t op;
		logic [STEP_W-1:0] step;
		logic [SPEED_W-1:0] fwd;
		logic [SPEED_W-1:0] rev;
		logic is_forward;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		status_t status;
	} res_t;
endpackage

// File: rtl/core/spit_front.sv
// Front part: accept input words and push them into a
// two-entry command queue. Depends on spit_pkg.
`timescale 1ns / 1ps
module spit_front
	import spit_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cmd_t in_cmd,
	output logic q_valid,
	input logic q_ready,
	output cmd_t q_cmd
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: rtl/core/spit_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on spit_pkg.
`timescale 1ns / 1ps
module spit_div
	import spit_pkg::*;
#(
	parameter int NW = 48,
	parameter int DW = 14
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0] r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] n_q;
	logic busy_q;
	logic [DW:0] trial;

	assign trial = {r_q[DW-1:0], q_q[NW-1]};
	assign quo = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= CW'(NW);
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// File: rtl/core/spit_back.sv
// Back part: table storage, scan for neighbor keys, interpolation through
// the serial divider, and the result register. Depends on spit_pkg, spit_div.
`timescale 1ns / 1ps
module spit_back
	import spit_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_ENTRIES,
	parameter int FULL_SCALE_STEP = DEF_FULL_SCALE
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input cmd_t q_cmd,
	output logic res_valid,
	input logic res_ready,
	output res_t res
);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 2);
	localparam int KW = (FULL_SCALE_STEP >= 1024) ? 14 : 12;
	localparam int NW = SPEED_W + KW + 2;
	localparam int DW = KW;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SCAN = 7'b0000010,
		S_EVAL = 7'b0000100,
		S_MUL = 7'b0001000,
		S_DIV = 7'b0010000,
		S_FIN = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t st_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [STEP_W-1:0] key_m [TABLE_ENTRIES];
	logic [SPEED_W-1:0] fwd_m [TABLE_ENTRIES];
	logic [SPEED_W-1:0] rev_m [TABLE_ENTRIES];
	logic has_fwd_q, has_rev_q;
	cmd_t cmd_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] idx;
	// registered read of the entry addressed in the previous cycle
	logic [STEP_W-1:0] rk_s1;
	logic [SPEED_W-1:0] rf_s1, rr_s1;
	logic rv_s1;
	logic [IW-1:0] i_s1;
	logic dir_q, second_q;

	// scan results
	logic hit_q, free_ok_q;
	logic [IW-1:0] hit_i_q, free_i_q;
	logic [SPEED_W-1:0] hit_f_q, hit_r_q;
	logic fh_q, fl_q, rh_q, rl_q;
	logic [STEP_W-1:0] fhk_q, flk_q, rhk_q, rlk_q;
	logic [SPEED_W-1:0] fhv_q, flv_q, rhv_q, rlv_q;

	// arithmetic job
	logic neg_q;
	logic [SPEED_W:0] mag_q;
	logic [KW-1:0] mulb_q, den_q;
	logic [SPEED_W-1:0] base_q;
	logic sat_q;
	logic [NW-1:0] prod_q;
	logic div_start, div_done;
	logic [NW-1:0] quo;
	logic [SPEED_W-1:0] speed_q;
	status_t status_q;
	logic [SPEED_W-1:0] dir_val;
	logic dir_imm;

	assign idx = idx_q[IW-1:0];
	assign q_ready = (st_q == S_IDLE);
	assign res_valid = (st_q == S_OUT);
	assign res.speed = speed_q;
	assign res.status = status_q;

	spit_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(prod_q), .den(den_q), .done(div_done), .quo(quo)
	);

	// set up one direction: either an immediate value or a mul/div job
	logic [STEP_W-1:0] s;
	logic imm;
	logic [SPEED_W-1:0] immv;
	logic j_neg, j_sat;
	logic [SPEED_W:0] j_mag;
	logic [KW-1:0] j_b, j_d;
	logic [SPEED_W-1:0] j_base;
	always_comb begin
		s = cmd_q.step;
		imm = 1'b1;
		immv = '0;
		j_neg = 1'b0;
		j_sat = 1'b0;
		j_mag = '0;
		j_b = '0;
		j_d = KW'(1);
		j_base = '0;
		if (dir_q) begin
			if (hit_q) immv = hit_f_q;
			else if (fh_q) begin
				imm = 1'b0;
				if (fl_q) begin
					j_neg = fhv_q < flv_q;
					j_mag = j_neg ? {1'b0, flv_q} - {1'b0, fhv_q}
						: {1'b0, fhv_q} - {1'b0, flv_q};
					j_b = KW'(s) - KW'(flk_q);
					j_d = KW'(fhk_q) - KW'(flk_q);
					j_base = flv_q;
				end else begin
					j_mag = {1'b0, fhv_q};
					j_b = KW'(s);
					j_d = KW'(fhk_q);
				end
			end
		end else begin
			if (s == '0 || !has_rev_q) immv = '0;
			else if (hit_q && hit_r_q != '0) immv = hit_r_q;
			else if (!rl_q) begin
				if (rh_q) begin
					imm = 1'b0;
					j_mag = {1'b0, rhv_q};
					j_b = KW'(s);
					j_d = KW'(rhk_q);
				end
			end else if (!rh_q) begin
				if (KW'(rlk_q) >= KW'(FULL_SCALE_STEP)) immv = rlv_q;
				else begin
					imm = 1'b0;
					j_sat = 1'b1;
					j_mag = {1'b0, rlv_q};
					j_b = KW'(FULL_SCALE_STEP) - KW'(rlk_q) - KW'(rlk_q) + KW'(s);
					j_d = KW'(FULL_SCALE_STEP) - KW'(rlk_q);
				end
			end else begin
				imm = 1'b0;
				j_neg = rhv_q < rlv_q;
				j_mag = j_neg ? {1'b0, rlv_q} - {1'b0, rhv_q}
					: {1'b0, rhv_q} - {1'b0, rlv_q};
				j_b = KW'(s) - KW'(rlk_q);
				j_d = KW'(rhk_q) - KW'(rlk_q);
				j_base = rlv_q;
			end
		end
		dir_imm = imm;
		dir_val = immv;
	end

	// finish of a job: add the offset to base or subtract it, or saturate
	logic [SPEED_W-1:0] job_val;
	logic [NW-1:0] sum;
	always_comb begin
		sum = neg_q ? NW'(base_q) - quo : NW'(base_q) + quo;
		if (sat_q) job_val = (quo > NW'(24'hFFFFFF)) ? 24'hFFFFFF : quo[SPEED_W-1:0];
		else job_val = sum[SPEED_W-1:0];
	end

	// divider input needs prod before start: start in the cycle after MUL
	logic div_go_q;
	assign div_start = div_go_q;

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && q_valid) cmd_q <= q_cmd;
		rk_s1 <= key_m[idx];
		rf_s1 <= fwd_m[idx];
		rr_s1 <= rev_m[idx];
		rv_s1 <= valid_q[idx];
		i_s1 <= idx;
		if (st_q == S_EVAL) begin
			neg_q <= j_neg;
			sat_q <= j_sat;
			mag_q <= j_mag;
			mulb_q <= j_b;
			den_q <= j_d;
			base_q <= j_base;
		end
		if (st_q == S_MUL) prod_q <= NW'(mag_q) * NW'(mulb_q);
		if (st_q == S_SCAN && cmd_q.op == OP_WRITE && idx_q == CW'(TABLE_ENTRIES + 1)) begin
			if (hit_q || free_ok_q) begin
				key_m[hit_q ? hit_i_q : free_i_q] <= cmd_q.step;
				fwd_m[hit_q ? hit_i_q : free_i_q] <= cmd_q.fwd;
				rev_m[hit_q ? hit_i_q : free_i_q] <= cmd_q.rev;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			valid_q <= '0;
			has_fwd_q <= 1'b0;
			has_rev_q <= 1'b0;
			idx_q <= '0;
			dir_q <= 1'b0;
			second_q <= 1'b0;
			hit_q <= 1'b0;
			free_ok_q <= 1'b0;
			fh_q <= 1'b0; fl_q <= 1'b0; rh_q <= 1'b0; rl_q <= 1'b0;
			speed_q <= '0;
			status_q <= ST_OK;
			div_go_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						st_q <= S_SCAN;
						idx_q <= '0;
						hit_q <= 1'b0; free_ok_q <= 1'b0;
						fh_q <= 1'b0; fl_q <= 1'b0; rh_q <= 1'b0; rl_q <= 1'b0;
						dir_q <= q_cmd.is_forward;
						second_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (idx_q != CW'(TABLE_ENTRIES + 1)) begin
						idx_q <= idx_q + 1'b1;
						// the read stage holds entry idx_q - 1
						if (idx_q != '0) begin
							if (rv_s1) begin
								if (rk_s1 == cmd_q.step && !hit_q) begin
									hit_q <= 1'b1; hit_i_q <= i_s1;
									hit_f_q <= rf_s1; hit_r_q <= rr_s1;
								end
								if (rk_s1 > cmd_q.step && (!fh_q || rk_s1 < fhk_q)) begin
									fh_q <= 1'b1; fhk_q <= rk_s1; fhv_q <= rf_s1;
								end
								if (rk_s1 < cmd_q.step && (!fl_q || rk_s1 > flk_q)) begin
									fl_q <= 1'b1; flk_q <= rk_s1; flv_q <= rf_s1;
								end
								if (rr_s1 != '0 && rk_s1 > cmd_q.step
										&& (!rh_q || rk_s1 < rhk_q)) begin
									rh_q <= 1'b1; rhk_q <= rk_s1; rhv_q <= rr_s1;
								end
								if (rr_s1 != '0 && rk_s1 < cmd_q.step
										&& (!rl_q || rk_s1 > rlk_q)) begin
									rl_q <= 1'b1; rlk_q <= rk_s1; rlv_q <= rr_s1;
								end
							end else if (!free_ok_q) begin
								free_ok_q <= 1'b1; free_i_q <= i_s1;
							end
						end
					end else begin
						speed_q <= '0;
						status_q <= ST_OK;
						priority case (cmd_q.op)
							OP_WRITE: begin
								st_q <= S_OUT;
								if (hit_q || free_ok_q) begin
									valid_q[hit_q ? hit_i_q : free_i_q] <= 1'b1;
									if (cmd_q.fwd != '0) has_fwd_q <= 1'b1;
									if (cmd_q.rev != '0) has_rev_q <= 1'b1;
								end else status_q <= ST_FULL;
							end
							OP_DELETE: begin
								st_q <= S_OUT;
								if (hit_q) valid_q[hit_i_q] <= 1'b0;
							end
							OP_CLEAR: begin
								st_q <= S_OUT;
								valid_q <= '0;
								has_fwd_q <= 1'b0;
								has_rev_q <= 1'b0;
							end
							default: st_q <= S_EVAL;
						endcase
					end
				end
				S_EVAL: begin
					if (dir_imm) begin
						if (dir_val != '0) begin
							speed_q <= dir_val; st_q <= S_OUT;
						end else if (!second_q) begin
							second_q <= 1'b1; dir_q <= ~dir_q;
						end else begin
							status_q <= ST_NO_DATA; st_q <= S_OUT;
						end
					end else st_q <= S_MUL;
				end
				S_MUL: begin
					st_q <= S_DIV;
					div_go_q <= 1'b1;
				end
				S_DIV: begin
					div_go_q <= 1'b0;
					if (div_done) st_q <= S_FIN;
				end
				S_FIN: begin
					if (job_val != '0) begin
						speed_q <= job_val; st_q <= S_OUT;
					end else if (!second_q) begin
						second_q <= 1'b1; dir_q <= ~dir_q; st_q <= S_EVAL;
					end else begin
						status_q <= ST_NO_DATA; st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_ready) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/speed_profile_interpolation_table.sv
// Top level of the speed profile interpolation table.
// Depends on spit_pkg, spit_front, spit_back.
//
// Usage:
//  s_axis carries one command word: op, step, forward/reverse speed, and
//  the query direction in tuser. m_axis returns exactly one word per
//  command: speed and status.
//  Every command scans all TABLE_ENTRIES entries, one per cycle, behind a
//  registered read; write, delete and clear end after the scan. A query
//  that interpolates adds, for each direction tried, a multiply and a
//  38-bit serial divide (40-bit when FULL_SCALE_STEP is 1024 or more), one
//  quotient bit per cycle. The scan over the table and the divider set the
//  rate; one command is worked on at a time.
//  A two-word queue in front lets the sender post commands while the back
//  part is busy or its result is stalled.
//  Reset empties the table and clears both has-speed flags.
//  When the receiver stalls, hold the result word in place; the queue
//  keeps taking words until it is full.
`timescale 1ns / 1ps
module speed_profile_interpolation_table
	import spit_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_ENTRIES,
	parameter int FULL_SCALE_STEP = DEF_FULL_SCALE
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata, // op, step, forward_speed, reverse_speed
	input logic s_axis_tuser, // is_forward
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata // speed, status
);
	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;
	res_t res;

	// unpack the input word
	assign in_cmd.op = op_t'(s_axis_tdata[1:0]);
	assign in_cmd.step = s_axis_tdata[11:2];
	assign in_cmd.fwd = s_axis_tdata[35:12];
	assign in_cmd.rev = s_axis_tdata[59:36];
	assign in_cmd.is_forward = s_axis_tuser;

	spit_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	spit_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES), .FULL_SCALE_STEP(FULL_SCALE_STEP)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {6'd0, res.status, res.speed};

	// no data is reported with a zero speed
	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[25:24] == ST_NO_DATA |-> m_axis_tdata[23:0] == '0)
		else $error("no-data result carries a speed");
	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// status never takes the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[25:24] != 2'd3)
		else $error("bad status code");
endmodule
